// ===== rtl/crxf_pkg.sv =====
package crxf_pkg;

    localparam int unsigned RING_DEPTH_DFLT = 64;

    localparam int unsigned OP_W       = 2;
    localparam int unsigned STAMP_W    = 64;
    localparam int unsigned ID_W       = 29;
    localparam int unsigned DLC_W      = 4;
    localparam int unsigned PAYLOAD_W  = 64;
    localparam int unsigned ALERT_W    = 7;
    localparam int unsigned STATE_W    = 2;
    localparam int unsigned CNT_W      = 32;
    localparam int unsigned CFG_ADDR_W = 2;
    localparam int unsigned CFG_DATA_W = 29;

    localparam int unsigned FRAME_W     = STAMP_W + ID_W + 2 + DLC_W + PAYLOAD_W;
    localparam int unsigned IN_FIELDS_W = FRAME_W + ALERT_W;
    localparam int unsigned IN_DATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;

    typedef enum logic [OP_W-1:0] {
        OP_RX     = 2'd0,
        OP_POP    = 2'd1,
        OP_ALERT  = 2'd2,
        OP_RX_ERR = 2'd3
    } t_op;

    localparam logic [CFG_ADDR_W-1:0] CFG_FILTER_ENABLE = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_FILTER_CODE   = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_FILTER_MASK   = 2'd2;

    localparam logic [STATE_W-1:0] BUS_STOPPED    = 2'd0;
    localparam logic [STATE_W-1:0] BUS_RUNNING    = 2'd1;
    localparam logic [STATE_W-1:0] BUS_OFF        = 2'd2;
    localparam logic [STATE_W-1:0] BUS_RECOVERING = 2'd3;

    localparam int unsigned ALERT_BUS_OFF    = 0;
    localparam int unsigned ALERT_RECOVERING = 1;
    localparam int unsigned ALERT_RECOVERED  = 2;
    localparam int unsigned ALERT_ERR_PASS   = 3;
    localparam int unsigned ALERT_BUS_ERR    = 4;
    localparam int unsigned ALERT_QUEUE_FULL = 5;
    localparam int unsigned ALERT_TX_FAILED  = 6;

    // stamp in the low bits, payload on top
    typedef struct packed {
        logic [PAYLOAD_W-1:0] payload;
        logic [DLC_W-1:0]     dlc;
        logic                 remote;
        logic                 extended;
        logic [ID_W-1:0]      id;
        logic [STAMP_W-1:0]   stamp;
    } t_frame;

    function automatic int unsigned fill_w(input int unsigned depth);
        return $clog2(depth + 1);
    endfunction

    function automatic int unsigned out_data_w(input int unsigned depth);
        return ((FRAME_W + fill_w(depth) + STATE_W + 2 * CNT_W + 7) / 8) * 8;
    endfunction

endpackage

// ===== rtl/can_rx_filter_overwrite_fifo_core.sv =====
// CAN receive filter with an overwriting receive ring. Each request carries
// an op in s_axis_tuser: receive frame, pop, alert, receive error; each gives
// exactly one result on m_axis. A request is accepted every cycle when the
// output side keeps up; on its way to m_axis a result passes through the
// synchronous ring memory read register and then the output register.
// The ring holds RING_DEPTH frames in one memory with one write and one read
// port; when full, a new frame replaces the oldest. Configuration writes are
// taken at any time but should only be issued while no request is in flight.
module can_rx_filter_overwrite_fifo_core #(
    parameter int unsigned RING_DEPTH = crxf_pkg::RING_DEPTH_DFLT
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_cfg_we,
    input  logic [crxf_pkg::CFG_ADDR_W-1:0]           i_cfg_addr,
    input  logic [crxf_pkg::CFG_DATA_W-1:0]           i_cfg_wdata,
    input  logic                                      s_axis_tvalid,
    output logic                                      s_axis_tready,
    // rx_stamp, rx_id, rx_extended, rx_remote, rx_dlc, rx_payload, alert_bits
    input  logic [crxf_pkg::IN_DATA_W-1:0]            s_axis_tdata,
    // op
    input  logic [crxf_pkg::OP_W-1:0]                 s_axis_tuser,
    output logic                                      m_axis_tvalid,
    input  logic                                      m_axis_tready,
    // out_stamp, out_id, out_extended, out_remote, out_dlc, out_payload,
    // frames_waiting, bus_state, rx_total, err_total
    output logic [crxf_pkg::out_data_w(RING_DEPTH)-1:0] m_axis_tdata,
    // popped_valid
    output logic [0:0]                                m_axis_tuser
);

    localparam int unsigned AW     = $clog2(RING_DEPTH);
    localparam int unsigned FW     = crxf_pkg::fill_w(RING_DEPTH);
    localparam int unsigned OUT_W  = crxf_pkg::out_data_w(RING_DEPTH);
    localparam int unsigned USED_W = crxf_pkg::FRAME_W + FW + crxf_pkg::STATE_W
                                     + 2 * crxf_pkg::CNT_W;

    function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] idx);
        return (idx == AW'(RING_DEPTH - 1)) ? '0 : idx + 1'b1;
    endfunction

    crxf_pkg::t_frame mem [RING_DEPTH];

    logic                            r_flt_en;
    logic [crxf_pkg::ID_W-1:0]       r_flt_code;
    logic [crxf_pkg::ID_W-1:0]       r_flt_mask;

    logic [AW-1:0]                   r_wr_idx, n_wr_idx;
    logic [AW-1:0]                   r_rd_idx, n_rd_idx;
    logic [FW-1:0]                   r_fill, n_fill;
    logic [crxf_pkg::STATE_W-1:0]    r_bus, n_bus;
    logic [crxf_pkg::CNT_W-1:0]      r_rx_total, n_rx_total;
    logic [crxf_pkg::CNT_W-1:0]      r_err_total, n_err_total;
    logic                            n_pop;

    logic                            r_s1_valid;
    logic                            r_s1_pop;
    crxf_pkg::t_frame                r_rd_frame;

    logic                            r_out_valid;
    logic                            r_out_pop;
    crxf_pkg::t_frame                r_out_frame;
    logic [FW-1:0]                   r_out_fill;
    logic [crxf_pkg::STATE_W-1:0]    r_out_bus;
    logic [crxf_pkg::CNT_W-1:0]      r_out_rx;
    logic [crxf_pkg::CNT_W-1:0]      r_out_err;

    crxf_pkg::t_op                   op;
    crxf_pkg::t_frame                in_frame;
    logic [crxf_pkg::ALERT_W-1:0]    alert;
    logic                            match;
    logic                            accept;
    logic                            s1_move;
    logic                            mem_we;

    assign op       = crxf_pkg::t_op'(s_axis_tuser);
    assign in_frame = crxf_pkg::t_frame'(s_axis_tdata[crxf_pkg::FRAME_W-1:0]);
    assign alert    = s_axis_tdata[crxf_pkg::FRAME_W +: crxf_pkg::ALERT_W];
    assign match    = !r_flt_en || (((in_frame.id ^ r_flt_code) & r_flt_mask) == '0);

    assign s1_move       = r_s1_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_s1_valid || s1_move;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign mem_we        = accept && (op == crxf_pkg::OP_RX) && match;

    always_comb begin
        n_wr_idx    = r_wr_idx;
        n_rd_idx    = r_rd_idx;
        n_fill      = r_fill;
        n_bus       = r_bus;
        n_rx_total  = r_rx_total;
        n_err_total = r_err_total;
        n_pop       = 1'b0;
        unique case (op)
            crxf_pkg::OP_RX: begin
                if (match) begin
                    n_wr_idx   = next_slot(r_wr_idx);
                    n_rx_total = r_rx_total + 1'b1;
                    if (r_fill == FW'(RING_DEPTH)) begin
                        n_rd_idx = next_slot(r_rd_idx);
                    end else begin
                        n_fill = r_fill + 1'b1;
                    end
                end
            end
            crxf_pkg::OP_POP: begin
                if (r_fill != '0) begin
                    n_pop    = 1'b1;
                    n_rd_idx = next_slot(r_rd_idx);
                    n_fill   = r_fill - 1'b1;
                end
            end
            crxf_pkg::OP_ALERT: begin
                if (alert[crxf_pkg::ALERT_BUS_OFF]) begin
                    n_bus = crxf_pkg::BUS_OFF;
                end
                if (alert[crxf_pkg::ALERT_RECOVERING]) begin
                    n_bus = crxf_pkg::BUS_RECOVERING;
                end
                if (alert[crxf_pkg::ALERT_RECOVERED]) begin
                    n_bus = crxf_pkg::BUS_STOPPED;
                end
                n_err_total = r_err_total + crxf_pkg::CNT_W'($countones({
                    alert[crxf_pkg::ALERT_TX_FAILED],
                    alert[crxf_pkg::ALERT_QUEUE_FULL],
                    alert[crxf_pkg::ALERT_BUS_ERR],
                    alert[crxf_pkg::ALERT_ERR_PASS],
                    alert[crxf_pkg::ALERT_BUS_OFF]}));
            end
            crxf_pkg::OP_RX_ERR: begin
                n_err_total = r_err_total + 1'b1;
            end
            default: begin
            end
        endcase
    end

    // ring memory: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[r_wr_idx] <= in_frame;
        end
        if (accept) begin
            r_rd_frame <= mem[r_rd_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flt_en   <= 1'b0;
            r_flt_code <= '0;
            r_flt_mask <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                crxf_pkg::CFG_FILTER_ENABLE: r_flt_en   <= i_cfg_wdata[0];
                crxf_pkg::CFG_FILTER_CODE:   r_flt_code <= i_cfg_wdata;
                crxf_pkg::CFG_FILTER_MASK:   r_flt_mask <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_idx    <= '0;
            r_rd_idx    <= '0;
            r_fill      <= '0;
            r_bus       <= crxf_pkg::BUS_RUNNING;
            r_rx_total  <= '0;
            r_err_total <= '0;
            r_s1_valid  <= 1'b0;
            r_s1_pop    <= 1'b0;
        end else begin
            if (accept) begin
                r_wr_idx    <= n_wr_idx;
                r_rd_idx    <= n_rd_idx;
                r_fill      <= n_fill;
                r_bus       <= n_bus;
                r_rx_total  <= n_rx_total;
                r_err_total <= n_err_total;
                r_s1_pop    <= n_pop;
                r_s1_valid  <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid  <= 1'b0;
            end
        end
    end

    // live state still belongs to the stage-1 request when it moves out
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_out_pop   <= 1'b0;
        end else if (s1_move) begin
            r_out_valid <= 1'b1;
            r_out_pop   <= r_s1_pop;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_out_frame <= r_s1_pop ? r_rd_frame : '0;
            r_out_fill  <= r_fill;
            r_out_bus   <= r_bus;
            r_out_rx    <= r_rx_total;
            r_out_err   <= r_err_total;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_pop;
    assign m_axis_tdata  = {{(OUT_W - USED_W){1'b0}}, r_out_err, r_out_rx, r_out_bus,
                            r_out_fill, r_out_frame};

endmodule

// ===== rtl/crxf_checker.sv =====
module crxf_checker #(
    parameter int unsigned RING_DEPTH = crxf_pkg::RING_DEPTH_DFLT
) (
    input logic                                        i_clk,
    input logic                                        i_rst_n,
    input logic                                        s_axis_tready,
    input logic                                        m_axis_tvalid,
    input logic                                        m_axis_tready,
    input logic [crxf_pkg::out_data_w(RING_DEPTH)-1:0] m_axis_tdata,
    input logic [0:0]                                  m_axis_tuser
);

    localparam int unsigned FW = crxf_pkg::fill_w(RING_DEPTH);

    logic [FW-1:0] fill;
    assign fill = m_axis_tdata[crxf_pkg::FRAME_W +: FW];

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    a_fill_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> fill <= FW'(RING_DEPTH))
        else $error("frames_waiting above ring depth");

    a_pop_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> fill < FW'(RING_DEPTH))
        else $error("pop left a full ring");

    a_nopop_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[crxf_pkg::FRAME_W-1:0] == '0)
        else $error("frame fields nonzero without pop");

    a_busy_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled while output free");

endmodule

bind can_rx_filter_overwrite_fifo_core crxf_checker #(
    .RING_DEPTH(RING_DEPTH)
) u_crxf_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// ===== test/testbench.sv =====
module testbench;

    localparam int unsigned OP_W       = crxf_pkg::OP_W;
    localparam int unsigned ID_W       = crxf_pkg::ID_W;
    localparam int unsigned ALERT_W    = crxf_pkg::ALERT_W;
    localparam int unsigned STATE_W    = crxf_pkg::STATE_W;
    localparam int unsigned CNT_W      = crxf_pkg::CNT_W;
    localparam int unsigned CFG_ADDR_W = crxf_pkg::CFG_ADDR_W;
    localparam int unsigned CFG_DATA_W = crxf_pkg::CFG_DATA_W;
    localparam int unsigned FRAME_W    = crxf_pkg::FRAME_W;
    localparam int unsigned IN_DATA_W  = crxf_pkg::IN_DATA_W;

    localparam int unsigned DEPTH   = crxf_pkg::RING_DEPTH_DFLT;
    localparam int unsigned FILL_W  = crxf_pkg::fill_w(DEPTH);
    localparam int unsigned OUT_W   = crxf_pkg::out_data_w(DEPTH);
    localparam int unsigned OFF_ST  = FRAME_W + FILL_W;
    localparam int unsigned OFF_RX  = OFF_ST + STATE_W;
    localparam int unsigned OFF_ERR = OFF_RX + CNT_W;
    localparam logic [CFG_ADDR_W-1:0] CFG_UNUSED = 2'd3;
    localparam logic [ID_W-1:0] ID_ALL = '1;

    typedef struct packed {
        logic               popped;
        crxf_pkg::t_frame   frame;
        logic [FILL_W-1:0]  fill;
        logic [STATE_W-1:0] state;
        logic [CNT_W-1:0]   rx_total;
        logic [CNT_W-1:0]   err_total;
    } t_rx_result;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_addr = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic [OP_W-1:0]       s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b1;
    logic [OUT_W-1:0]      m_axis_tdata;
    logic [0:0]            m_axis_tuser;

    can_rx_filter_overwrite_fifo_core #(.RING_DEPTH(DEPTH)) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor state
    logic              flt_en = 1'b0;
    logic [ID_W-1:0]   flt_code = '0;
    logic [ID_W-1:0]   flt_mask = '0;
    crxf_pkg::t_frame  ring_mem [DEPTH];
    int                wr_ptr = 0;
    int                rd_ptr = 0;
    int                fill_cnt = 0;
    logic [STATE_W-1:0] bus_st = crxf_pkg::BUS_RUNNING;
    logic [CNT_W-1:0]  rx_cnt = '0;
    logic [CNT_W-1:0]  err_cnt = '0;

    t_rx_result        pending_results [$];
    int                n_errs = 0;
    int                idle_pct = 0;
    int                stall_pct = 0;

    function automatic t_rx_result rx_ring_predict(crxf_pkg::t_op op, crxf_pkg::t_frame fr,
                                                   logic [ALERT_W-1:0] alert);
        t_rx_result r;
        r = '0;
        case (op)
            crxf_pkg::OP_RX: begin
                if (!flt_en || ((fr.id & flt_mask) == (flt_code & flt_mask))) begin
                    ring_mem[wr_ptr] = fr;
                    wr_ptr = (wr_ptr + 1) % DEPTH;
                    if (fill_cnt == DEPTH)
                        rd_ptr = (rd_ptr + 1) % DEPTH;
                    else
                        fill_cnt++;
                    rx_cnt++;
                end
            end
            crxf_pkg::OP_POP: begin
                if (fill_cnt != 0) begin
                    r.popped = 1'b1;
                    r.frame = ring_mem[rd_ptr];
                    rd_ptr = (rd_ptr + 1) % DEPTH;
                    fill_cnt--;
                end
            end
            crxf_pkg::OP_ALERT: begin
                if (alert[crxf_pkg::ALERT_BUS_OFF]) begin
                    bus_st = crxf_pkg::BUS_OFF;
                    err_cnt++;
                end
                if (alert[crxf_pkg::ALERT_RECOVERING]) bus_st = crxf_pkg::BUS_RECOVERING;
                if (alert[crxf_pkg::ALERT_RECOVERED]) bus_st = crxf_pkg::BUS_STOPPED;
                if (alert[crxf_pkg::ALERT_ERR_PASS]) err_cnt++;
                if (alert[crxf_pkg::ALERT_BUS_ERR]) err_cnt++;
                if (alert[crxf_pkg::ALERT_QUEUE_FULL]) err_cnt++;
                if (alert[crxf_pkg::ALERT_TX_FAILED]) err_cnt++;
            end
            default: err_cnt++;
        endcase
        r.fill = FILL_W'(fill_cnt);
        r.state = bus_st;
        r.rx_total = rx_cnt;
        r.err_total = err_cnt;
        return r;
    endfunction

    task automatic send_req(crxf_pkg::t_op op, crxf_pkg::t_frame fr,
                            logic [ALERT_W-1:0] alert);
        logic [IN_DATA_W-1:0] word;
        word = '0;
        word[FRAME_W-1:0] = fr;
        word[FRAME_W +: ALERT_W] = alert;
        while ($urandom_range(99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= word;
        s_axis_tuser <= op;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        pending_results.push_back(rx_ring_predict(op, fr, alert));
    endtask

    task automatic cfg_write(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= addr;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        case (addr)
            crxf_pkg::CFG_FILTER_ENABLE: flt_en = data[0];
            crxf_pkg::CFG_FILTER_CODE:   flt_code = data;
            crxf_pkg::CFG_FILTER_MASK:   flt_mask = data;
            default: ;
        endcase
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // holds off the sender until every outstanding request has its result
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic crxf_pkg::t_frame rand_frame();
        crxf_pkg::t_frame fr;
        fr.stamp = {$urandom, $urandom};
        fr.payload = {$urandom, $urandom};
        fr.extended = 1'($urandom_range(1));
        fr.remote = 1'($urandom_range(1));
        fr.dlc = 4'($urandom_range(15));
        case ($urandom_range(2))
            0: fr.id = ID_W'($urandom);
            1: fr.id = ID_W'($urandom_range(11'h7ff));
            default: fr.id = (flt_code & flt_mask) | (ID_W'($urandom) & ~flt_mask);
        endcase
        return fr;
    endfunction

    function automatic logic [ALERT_W-1:0] rand_alert();
        if ($urandom_range(1))
            return ALERT_W'(1) << $urandom_range(ALERT_W - 1);
        return ALERT_W'($urandom_range(127));
    endfunction

    task automatic send_mix(int n, int rx_pct, int pop_pct);
        int r;
        crxf_pkg::t_op op;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(99);
            if (r < rx_pct) op = crxf_pkg::OP_RX;
            else if (r < rx_pct + pop_pct) op = crxf_pkg::OP_POP;
            else if (r < rx_pct + pop_pct + (100 - rx_pct - pop_pct) / 2)
                op = crxf_pkg::OP_ALERT;
            else op = crxf_pkg::OP_RX_ERR;
            send_req(op, rand_frame(), rand_alert());
        end
    endtask

    task automatic test_directed();
        crxf_pkg::t_frame fr;
        send_req(crxf_pkg::OP_POP, '0, '0);               // empty ring
        send_req(crxf_pkg::OP_ALERT, '0, '0);             // no state bit
        send_req(crxf_pkg::OP_RX, '0, '0);
        send_req(crxf_pkg::OP_RX, '1, '1);
        fr = rand_frame();
        fr.id = 29'h7ff;
        fr.extended = 1'b0;
        fr.dlc = 4'd9;                                    // length code above eight
        send_req(crxf_pkg::OP_RX, fr, '0);
        repeat (4) send_req(crxf_pkg::OP_POP, '1, '1);
        for (int b = 0; b < ALERT_W; b++)
            send_req(crxf_pkg::OP_ALERT, '0, ALERT_W'(1) << b);
        send_req(crxf_pkg::OP_ALERT, '0, 7'h03);          // recovering after bus off
        send_req(crxf_pkg::OP_ALERT, '0, '1);
        send_req(crxf_pkg::OP_RX_ERR, '1, '1);
        send_req(crxf_pkg::OP_RX_ERR, '0, '0);
    endtask

    task automatic test_filter();
        settle();
        cfg_write(crxf_pkg::CFG_FILTER_ENABLE, CFG_DATA_W'(1));
        cfg_write(crxf_pkg::CFG_FILTER_CODE, CFG_DATA_W'($urandom));
        cfg_write(crxf_pkg::CFG_FILTER_MASK, ID_ALL);
        send_mix(40, 70, 20);
        settle();
        cfg_write(crxf_pkg::CFG_FILTER_CODE, ID_ALL);
        send_mix(40, 70, 20);
        settle();
        cfg_write(crxf_pkg::CFG_FILTER_CODE, '0);
        cfg_write(crxf_pkg::CFG_FILTER_MASK, '0);
        send_mix(40, 70, 20);
        settle();
        cfg_write(crxf_pkg::CFG_FILTER_CODE, CFG_DATA_W'($urandom));
        cfg_write(crxf_pkg::CFG_FILTER_MASK, CFG_DATA_W'($urandom));
        cfg_write(CFG_UNUSED, '1);                        // no such register
        send_mix(40, 70, 20);
        settle();
        cfg_write(crxf_pkg::CFG_FILTER_ENABLE, CFG_DATA_W'(0));
        send_mix(40, 60, 30);
    endtask

    task automatic test_overflow();
        settle();
        cfg_write(crxf_pkg::CFG_FILTER_ENABLE, CFG_DATA_W'(0));
        stall_pct = 12;
        for (int k = 0; k < DEPTH + 36; k++)
            send_req(crxf_pkg::OP_RX, rand_frame(), rand_alert());
        repeat (DEPTH + 6) send_req(crxf_pkg::OP_POP, rand_frame(), rand_alert());
        stall_pct = 0;
    endtask

    task automatic test_random();
        int idle_tab [4] = '{0, 69, 0, 12};
        int stall_tab [4] = '{0, 0, 69, 12};
        for (int p = 0; p < 4; p++) begin
            settle();
            cfg_write(crxf_pkg::CFG_FILTER_ENABLE, CFG_DATA_W'(p[0]));
            cfg_write(crxf_pkg::CFG_FILTER_CODE, CFG_DATA_W'($urandom));
            cfg_write(crxf_pkg::CFG_FILTER_MASK, CFG_DATA_W'($urandom & $urandom & $urandom));
            idle_pct = idle_tab[p];
            stall_pct = stall_tab[p];
            for (int k = 0; k < 2; k++) begin
                send_mix(91, 80, 10);           // fill up, wraps past full
                send_mix(91, 15, 70);           // drain, pops past empty
            end
        end
        idle_pct = 0;
        stall_pct = 0;
    endtask

    always @(posedge i_clk) m_axis_tready <= ($urandom_range(99) >= stall_pct);

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $error("%s expected 0x%0h got 0x%0h", name, want, got);
            n_errs++;
        end
    endfunction

    t_rx_result        want_res;
    crxf_pkg::t_frame  got_frame;

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                $error("result with no request outstanding");
                n_errs++;
            end else begin
                want_res = pending_results.pop_front();
                got_frame = m_axis_tdata[FRAME_W-1:0];
                check_field("popped_valid", 64'(want_res.popped), 64'(m_axis_tuser));
                check_field("out_stamp", want_res.frame.stamp, got_frame.stamp);
                check_field("out_id", 64'(want_res.frame.id), 64'(got_frame.id));
                check_field("out_extended", 64'(want_res.frame.extended),
                            64'(got_frame.extended));
                check_field("out_remote", 64'(want_res.frame.remote),
                            64'(got_frame.remote));
                check_field("out_dlc", 64'(want_res.frame.dlc), 64'(got_frame.dlc));
                check_field("out_payload", want_res.frame.payload, got_frame.payload);
                check_field("frames_waiting", 64'(want_res.fill),
                            64'(m_axis_tdata[FRAME_W +: FILL_W]));
                check_field("bus_state", 64'(want_res.state),
                            64'(m_axis_tdata[OFF_ST +: STATE_W]));
                check_field("rx_total", 64'(want_res.rx_total),
                            64'(m_axis_tdata[OFF_RX +: CNT_W]));
                check_field("err_total", 64'(want_res.err_total),
                            64'(m_axis_tdata[OFF_ERR +: CNT_W]));
            end
        end
    end

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_filter();
        test_overflow();
        test_random();
        settle();
        if (n_errs == 0 && pending_results.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial begin
        #3000000;
        $display("status: fail");
        $finish;
    end

endmodule
